@@ hw/rtl/assert_macros.svh @@
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition must hold on every clock edge outside reset
`define DSD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: always");
// antecedent at one edge implies consequent at the same edge
`define DSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same cycle");
// antecedent at one edge implies consequent at the next edge
`define DSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define DSD_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define DSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define DSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/dsd_pkg.sv @@
// types, constants and helpers for the disk seek distance block
package dsd_pkg;

    localparam int CYL_BITS  = 16;
    localparam int MAX_BATCH = 1024;
    localparam int SUM_BITS  = 26;
    localparam int DCYL_BITS = CYL_BITS + 1;
    localparam int SCAN_BITS = CYL_BITS + 3;

    localparam longint unsigned SUM_MAX  = (64'd1 << SUM_BITS) - 64'd1;
    localparam longint unsigned CEIL_RAW = 64'(MAX_BATCH) * ((64'd1 << CYL_BITS) - 64'd1);
    localparam logic [SUM_BITS-1:0] SAT_CEIL =
        SUM_BITS'((CEIL_RAW > SUM_MAX) ? SUM_MAX : CEIL_RAW);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY_MODE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_CYLINDER = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISK_CYLINDERS = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SWEEP_UP       = 2'd3;

    // policy codes
    localparam logic [1:0] POL_FCFS  = 2'd0;
    localparam logic [1:0] POL_SCAN  = 2'd1;
    localparam logic [1:0] POL_CSCAN = 2'd2;

    typedef struct packed {
        logic [CYL_BITS-1:0] cylinder;
        logic                last_request;
    } t_in;

    typedef struct packed {
        logic [SUM_BITS-1:0] total_movement;
        logic                saturated;
    } t_out;

    // batch summary handed from the tracker to the policy stage
    typedef struct packed {
        logic [CYL_BITS-1:0] head;
        logic [SUM_BITS-1:0] sum;
        logic [CYL_BITS-1:0] lowest;
        logic [CYL_BITS-1:0] highest;
        logic [CYL_BITS-1:0] near_below;
        logic [CYL_BITS-1:0] near_above;
        logic                seen_below;
        logic                seen_above;
    } t_snap;

    function automatic logic [CYL_BITS-1:0] cyl_dist(
        input logic [CYL_BITS-1:0] a,
        input logic [CYL_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // distance from the top cylinder, which may lie past the 16-bit range
    function automatic logic [DCYL_BITS-1:0] top_dist(
        input logic [DCYL_BITS-1:0] t,
        input logic [CYL_BITS-1:0]  c
    );
        logic [DCYL_BITS-1:0] cw;
        cw = DCYL_BITS'(c);
        return (t > cw) ? (t - cw) : (cw - t);
    endfunction

endpackage

@@ hw/rtl/dsd_track.sv @@
// per-request batch tracking: fcfs sum, extremes and nearest requests
module dsd_track import dsd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_in                 i_item,
    input  logic [CYL_BITS-1:0] i_start_cyl,
    output t_snap               o_snap
);

    logic                r_open;
    logic [CYL_BITS-1:0] r_pos;
    t_snap               r_st;

    logic [CYL_BITS-1:0] base_pos;
    t_snap               base;
    t_snap               n_st;
    logic [CYL_BITS-1:0] step_dist;
    logic [SUM_BITS:0]   sum_wide;
    logic [CYL_BITS-1:0] cyl;

    always_comb begin
        cyl = i_item.cylinder;
        // a new batch starts from cleared state and the current start cylinder
        if (r_open) begin
            base     = r_st;
            base_pos = r_pos;
        end else begin
            base.head       = i_start_cyl;
            base.sum        = '0;
            base.lowest     = '1;
            base.highest    = '0;
            base.near_below = '0;
            base.near_above = '1;
            base.seen_below = 1'b0;
            base.seen_above = 1'b0;
            base_pos        = i_start_cyl;
        end

        step_dist = cyl_dist(cyl, base_pos);
        sum_wide  = {1'b0, base.sum} + (SUM_BITS+1)'(step_dist);

        n_st     = base;
        n_st.sum = (sum_wide > {1'b0, SAT_CEIL}) ? SAT_CEIL : sum_wide[SUM_BITS-1:0];
        if (cyl < base.lowest) begin
            n_st.lowest = cyl;
        end
        if (cyl > base.highest) begin
            n_st.highest = cyl;
        end
        if (cyl < base.head) begin
            if (!base.seen_below || cyl > base.near_below) begin
                n_st.near_below = cyl;
            end
            n_st.seen_below = 1'b1;
        end else if (cyl > base.head) begin
            if (!base.seen_above || cyl < base.near_above) begin
                n_st.near_above = cyl;
            end
            n_st.seen_above = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_step) begin
            r_open <= !i_item.last_request;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_st  <= n_st;
            r_pos <= cyl;
        end
    end

    assign o_snap = n_st;

endmodule

@@ hw/rtl/dsd_policy.sv @@
// end-of-batch movement total for fcfs, scan and c-scan
module dsd_policy import dsd_pkg::*; (
    input  t_snap                i_snap,
    input  logic [1:0]           i_policy,
    input  logic [DCYL_BITS-1:0] i_disk_cyls,
    input  logic                 i_sweep_up,
    output t_out                 o_result
);

    logic [DCYL_BITS-1:0] top;
    logic [DCYL_BITS-1:0] d_top_head;
    logic [SCAN_BITS-1:0] leg_main;
    logic [SCAN_BITS-1:0] leg_back;
    logic [SUM_BITS-1:0]  total_raw;
    logic [SUM_BITS-1:0]  total;

    always_comb begin
        top        = (i_disk_cyls == '0) ? '0 : (i_disk_cyls - 1'b1);
        d_top_head = top_dist(top, i_snap.head);
        leg_main   = '0;
        leg_back   = '0;
        total_raw  = i_snap.sum;
        unique case (i_policy)
            POL_SCAN: begin
                if (i_sweep_up) begin
                    leg_main = SCAN_BITS'(d_top_head);
                    if (i_snap.seen_below) begin
                        leg_back = SCAN_BITS'(top_dist(top, i_snap.lowest));
                    end
                end else begin
                    leg_main = SCAN_BITS'(i_snap.head);
                    if (i_snap.seen_above) begin
                        leg_back = SCAN_BITS'(i_snap.highest);
                    end
                end
                total_raw = SUM_BITS'(leg_main + leg_back);
            end
            POL_CSCAN: begin
                if (i_sweep_up) begin
                    leg_main = SCAN_BITS'(d_top_head);
                    if (i_snap.seen_below) begin
                        leg_back = SCAN_BITS'(top) + SCAN_BITS'(i_snap.near_below);
                    end
                end else begin
                    leg_main = SCAN_BITS'(i_snap.head);
                    if (i_snap.seen_above) begin
                        leg_back = SCAN_BITS'(top)
                                 + SCAN_BITS'(top_dist(top, i_snap.near_above));
                    end
                end
                total_raw = SUM_BITS'(leg_main + leg_back);
            end
            default: begin
                total_raw = i_snap.sum;
            end
        endcase
        total = (total_raw > SAT_CEIL) ? SAT_CEIL : total_raw;
        o_result.total_movement = total;
        o_result.saturated      = (total == SAT_CEIL);
    end

endmodule

@@ hw/rtl/disk_seek_distance.sv @@
// top level of the disk seek distance block
// usage:
//   requests enter on the input channel (i_in_valid / o_in_stall), one cylinder
//   per transaction; the transaction with last_request set closes the batch
//   the only result per batch leaves on the output channel (o_out_valid /
//   i_out_stall) carrying the total head movement and a saturation flag
//   configuration writes use i_cfg_valid / o_cfg_ready with a register index;
//   o_cfg_ready is always high and writes are registered
// timing:
//   one request per cycle unless a final request waits on a stalled output;
//   the path is input register, tracker update, batch summary register,
//   policy adder, output register
// flow control:
//   non-final requests never wait on the output side; a final request waits
//   in the input register only while the summary and output registers are
//   both full and the receiver stalls, which then stalls the input
// reset:
//   synchronous active-low reset empties all stages, closes any open batch
//   and restores the register defaults (fcfs, head 0, 65536 cylinders, up)
module disk_seek_distance import dsd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in                     i_in_data,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out                    o_out_data,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DCYL_BITS-1:0]    i_cfg_data
);

`include "assert_macros.svh"

    // configuration registers
    logic [1:0]           r_policy;
    logic [CYL_BITS-1:0]  r_start_cyl;
    logic [DCYL_BITS-1:0] r_disk_cyls;
    logic                 r_sweep_up;

    // pipeline registers
    logic  r_in_valid;
    t_in   r_in;
    logic  r_snap_valid;
    t_snap r_snap;
    logic  r_out_valid;
    t_out  r_out;

    logic  n_in_valid;
    logic  n_snap_valid;
    logic  n_out_valid;

    // handshake terms
    logic  out_free;
    logic  snap_move;
    logic  snap_free;
    logic  in_move;
    logic  in_free;
    logic  in_acc;

    t_snap track_snap;
    t_out  policy_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_FCFS;
            r_start_cyl <= '0;
            r_disk_cyls <= DCYL_BITS'(1 << CYL_BITS);
            r_sweep_up  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLICY_MODE:    r_policy    <= i_cfg_data[1:0];
                CFG_START_CYLINDER: r_start_cyl <= i_cfg_data[CYL_BITS-1:0];
                CFG_DISK_CYLINDERS: r_disk_cyls <= i_cfg_data;
                CFG_SWEEP_UP:       r_sweep_up  <= i_cfg_data[0];
                default:            r_policy    <= r_policy;
            endcase
        end
    end

    // stage readiness, back to front
    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        snap_move = r_snap_valid && out_free;
        snap_free = !r_snap_valid || out_free;
        // only the final request needs room in the summary stage
        in_move   = r_in_valid && (!r_in.last_request || snap_free);
        in_free   = !r_in_valid || in_move;
        in_acc    = i_in_valid && in_free;

        n_in_valid   = in_acc || (r_in_valid && !in_move);
        n_snap_valid = (in_move && r_in.last_request) || (r_snap_valid && !snap_move);
        n_out_valid  = snap_move || (r_out_valid && i_out_stall);
    end

    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_snap_valid <= n_snap_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (in_move && r_in.last_request) begin
            r_snap <= track_snap;
        end
        if (snap_move) begin
            r_out <= policy_res;
        end
    end

    // running batch state, advanced once per request leaving the input register
    dsd_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_move),
        .i_item      (r_in),
        .i_start_cyl (r_start_cyl),
        .o_snap      (track_snap)
    );

    // policy total from the closed batch summary
    dsd_policy u_policy (
        .i_snap      (r_snap),
        .i_policy    (r_policy),
        .i_disk_cyls (r_disk_cyls),
        .i_sweep_up  (r_sweep_up),
        .o_result    (policy_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a non-final request never holds up the input register
    `DSD_ASSERT_SAME(a_nonlast_flows, i_clk, i_rst_n, r_in_valid && !r_in.last_request, in_move)
    // a new result only appears after a batch summary was waiting
    `DSD_ASSERT_SAME(a_out_from_snap, i_clk, i_rst_n, $rose(o_out_valid), $past(r_snap_valid))
    // a blocked batch summary is kept for the next cycle
    `DSD_ASSERT_NEXT(a_snap_held, i_clk, i_rst_n, r_snap_valid && !out_free, r_snap_valid)

endmodule

@@ dv/disk_seek_distance_tb.sv @@
// self-checking testbench for the disk seek distance block: directed and random batches
module disk_seek_distance_tb import dsd_pkg::*;;

    // the spare policy code behaves as first come first served
    localparam logic [1:0] POL_SPARE = 2'd3;
    // cycles of input hold-off before a register write, covering the result path
    localparam int SETTLE_CYCLES = 8;
    // one leg more than the ceiling allows, so the running sum has to clamp
    localparam int LONG_BATCH = MAX_BATCH + 1;
    // requests sent before the long batch, keeping the whole run near 1150
    localparam int RANDOM_REQUESTS = 1150 - LONG_BATCH;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    t_in                     i_in_data = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_out                    o_out_data;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [DCYL_BITS-1:0]    i_cfg_data = '0;

    // when set, neither side inserts gaps or stalls
    bit calm = 1'b0;
    int requests_sent = 0;

    disk_seek_distance i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // head-movement predictor plus the queue of batch totals still owed by the block
    class seek_scoreboard;
        logic [1:0]      policy;
        logic [15:0]     start_reg;
        logic [16:0]     disk_cyl;
        logic            sweep_up;
        bit              batch_open;
        longint unsigned head;
        longint unsigned position;
        longint unsigned moved;
        longint unsigned lowest;
        longint unsigned highest;
        longint unsigned near_below;
        longint unsigned near_above;
        bit              seen_below;
        bit              seen_above;
        t_out            totals_due[$];
        int              errors;

        function new();
            policy     = POL_FCFS;
            start_reg  = '0;
            disk_cyl   = 17'd65536;
            sweep_up   = 1'b1;
            batch_open = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DCYL_BITS-1:0] data);
            case (idx)
                CFG_POLICY_MODE:    policy    = data[1:0];
                CFG_START_CYLINDER: start_reg = data[15:0];
                CFG_DISK_CYLINDERS: disk_cyl  = data;
                CFG_SWEEP_UP:       sweep_up  = data[0];
                default: ;
            endcase
        endfunction

        function longint unsigned clamp(longint unsigned v);
            return (v > SAT_CEIL) ? longint'(SAT_CEIL) : v;
        endfunction

        function longint unsigned span(longint unsigned a, longint unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void note_request(t_in req);
            longint unsigned cyl;
            longint unsigned top;
            longint unsigned total;
            t_out            res;
            cyl = req.cylinder;
            // first request of a batch latches the head and clears the trackers
            if (!batch_open) begin
                head       = start_reg;
                position   = head;
                moved      = 0;
                lowest     = 16'hFFFF;
                highest    = 0;
                near_below = 0;
                near_above = 16'hFFFF;
                seen_below = 1'b0;
                seen_above = 1'b0;
                batch_open = 1'b1;
            end
            moved    = clamp(moved + span(cyl, position));
            position = cyl;
            if (cyl < lowest) lowest = cyl;
            if (cyl > highest) highest = cyl;
            if (cyl < head) begin
                if (!seen_below || cyl > near_below) near_below = cyl;
                seen_below = 1'b1;
            end else if (cyl > head) begin
                if (!seen_above || cyl < near_above) near_above = cyl;
                seen_above = 1'b1;
            end
            if (!req.last_request) return;

            top = (disk_cyl == 0) ? 0 : disk_cyl - 1;
            case (policy)
                POL_SCAN: begin
                    if (sweep_up) begin
                        total = span(top, head);
                        if (seen_below) total += span(top, lowest);
                    end else begin
                        total = head;
                        if (seen_above) total += highest;
                    end
                end
                POL_CSCAN: begin
                    if (sweep_up) begin
                        total = span(top, head);
                        if (seen_below) total += top + near_below;
                    end else begin
                        total = head;
                        if (seen_above) total += top + span(top, near_above);
                    end
                end
                default: total = moved;
            endcase
            total = clamp(total);
            res.total_movement = total[SUM_BITS-1:0];
            res.saturated      = (total == SAT_CEIL);
            totals_due.push_back(res);
            batch_open = 1'b0;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (totals_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual total %0d saturated %0b",
                         $time, got.total_movement, got.saturated);
                return;
            end
            want = totals_due.pop_front();
            if (got.total_movement !== want.total_movement) begin
                errors++;
                $display("%0t: total_movement mismatch, expected %0d, actual %0d",
                         $time, want.total_movement, got.total_movement);
            end
            if (got.saturated !== want.saturated) begin
                errors++;
                $display("%0t: saturated mismatch, expected %0b, actual %0b",
                         $time, want.saturated, got.saturated);
            end
        endfunction
    endclass

    seek_scoreboard sb = new();

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: check each transaction, then pick the stall for the next cycle
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if (stall_left != 0) stall_left--;
            else if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
            i_out_stall <= (stall_left != 0);
        end
    end

    // one request transaction; valid stays high into the next one when no gap follows
    task automatic send(input logic [15:0] cyl, input logic last);
        int  gap;
        t_in req;
        gap = pick_gap();
        req.cylinder     = cyl;
        req.last_request = last;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req);
        requests_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [DCYL_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // writes all four registers; unused upper data bits carry junk the block must ignore
    task automatic configure(input logic [1:0] pol, input logic [15:0] start,
                             input logic [16:0] dcyl, input logic up);
        cfg_write(CFG_POLICY_MODE, {15'($urandom), pol});
        cfg_write(CFG_START_CYLINDER, {1'($urandom), start});
        cfg_write(CFG_DISK_CYLINDERS, dcyl);
        cfg_write(CFG_SWEEP_UP, {16'($urandom), up});
        i_cfg_valid <= 1'b0;
    endtask

    // stop requests, collect every owed total, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.totals_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_cyl(input logic [15:0] cap, input logic [15:0] head);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return head;
        if (r == 1) return 16'd0;
        if (r == 2) return cap;
        if (r == 3) return 16'($urandom);
        return 16'($urandom_range(0, cap));
    endfunction

    task automatic run_random_phase();
        int          r;
        int          batches;
        int          len;
        bit          leave_open;
        logic [1:0]  pol;
        logic [16:0] dcyl;
        logic [15:0] start;
        logic [15:0] cap;
        calm = ($urandom_range(0, 5) == 0);

        r = $urandom_range(0, 9);
        pol = (r < 3) ? POL_FCFS : (r < 6) ? POL_SCAN : (r < 9) ? POL_CSCAN : POL_SPARE;

        // mostly the full disk or a random size, with the odd sizes mixed in
        r = $urandom_range(0, 19);
        if (r == 0) dcyl = 17'd0;
        else if (r == 1) dcyl = 17'd1;
        else if (r == 2) dcyl = 17'($urandom_range(65537, 131071));
        else if (r < 6) dcyl = 17'($urandom_range(2, 16));
        else if (r < 12) dcyl = 17'd65536;
        else dcyl = 17'($urandom_range(2, 65535));
        cap = (dcyl == 0) ? 16'd0 : (dcyl > 17'd65536) ? 16'hFFFF : 16'(dcyl - 1);

        r = $urandom_range(0, 9);
        if (r == 0) start = 16'd0;
        else if (r == 1) start = 16'hFFFF;
        else if (r == 2) start = 16'($urandom);
        else start = 16'($urandom_range(0, cap));

        configure(pol, start, dcyl, 1'($urandom));

        batches = $urandom_range(3, 12);
        // sometimes the phase ends mid-batch so the next start write meets an open batch
        leave_open = ($urandom_range(0, 9) == 0);
        for (int b = 0; b < batches; b++) begin
            r = $urandom_range(0, 19);
            if (r < 14) len = $urandom_range(1, 8);
            else if (r < 19) len = $urandom_range(9, 30);
            else len = $urandom_range(31, 100);
            for (int k = 0; k < len; k++)
                send(pick_cyl(cap, start),
                     (k == len - 1) && !(leave_open && b == batches - 1));
        end
        settle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: fcfs from head 0, full sweeps across the whole disk
        send(16'd0, 1'b0);
        send(16'hFFFF, 1'b0);
        send(16'd0, 1'b1);
        settle();

        // scan upward with a request on the head, one below, one above and the top cylinder
        configure(POL_SCAN, 16'd30000, 17'd65536, 1'b1);
        send(16'd30000, 1'b0);
        send(16'd100, 1'b0);
        send(16'hFFFF, 1'b0);
        send(16'd40000, 1'b1);
        settle();

        // scan downward, with and without requests above the head
        configure(POL_SCAN, 16'd30000, 17'd65536, 1'b0);
        send(16'd30000, 1'b0);
        send(16'd50000, 1'b1);
        send(16'd20000, 1'b1);
        settle();

        // c-scan upward on a small disk, with and without a wrap
        configure(POL_CSCAN, 16'd500, 17'd1000, 1'b1);
        send(16'd800, 1'b0);
        send(16'd200, 1'b0);
        send(16'd499, 1'b1);
        send(16'd700, 1'b1);
        settle();

        configure(POL_CSCAN, 16'd500, 17'd1000, 1'b0);
        send(16'd100, 1'b0);
        send(16'd900, 1'b0);
        send(16'd600, 1'b1);
        settle();

        // spare policy code on a zero-size disk, head at the highest 16-bit cylinder
        configure(POL_SPARE, 16'hFFFF, 17'd0, 1'b1);
        send(16'hFFFF, 1'b1);
        send(16'd0, 1'b1);
        settle();

        // zero-size disk under scan, with a request beyond the top cylinder
        configure(POL_SCAN, 16'd3, 17'd0, 1'b1);
        send(16'd5, 1'b0);
        send(16'd0, 1'b1);
        settle();

        // disk size past the 16-bit range
        configure(POL_CSCAN, 16'd10, 17'd131071, 1'b1);
        send(16'd3, 1'b1);
        settle();

        // a start write while a batch is open only applies to the following batch
        configure(POL_FCFS, 16'd10, 17'd65536, 1'b1);
        send(16'd20, 1'b0);
        settle();
        cfg_write(CFG_START_CYLINDER, 17'd40000);
        i_cfg_valid <= 1'b0;
        send(16'd30, 1'b1);
        send(16'd40000, 1'b1);
        settle();

        while (requests_sent < RANDOM_REQUESTS) run_random_phase();

        // long fcfs batch of full-stroke legs that runs into the ceiling
        calm = ($urandom_range(0, 1) == 0);
        configure(POL_FCFS, 16'd0, 17'd65536, 1'b1);
        for (int k = 0; k < LONG_BATCH; k++)
            send((k % 2 == 0) ? 16'hFFFF : 16'd0, k == LONG_BATCH - 1);

        i_in_valid <= 1'b0;
        while (sb.totals_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.totals_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #15000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
